// ===== hw/rtl/pis_pkg.sv =====
// pis_pkg: shared types and constants of the pid controller with integral separation
// holds the configuration struct, register indexes and fixed-point widths
// no dependencies
package pis_pkg;

	localparam int FRAC_BITS   = 8;
	localparam int SEP_NUM     = 77;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int INTEG_W     = 24;
	localparam int ERR_W       = 17;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_ENABLE   = 3'd5;

	localparam logic [14:0] LIMIT_RESET = 15'd32767;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [15:0] deriv_gain;
		logic [14:0] integ_limit;
		logic [14:0] output_limit;
		logic        separation_enable;
	} cfg_t;

	// controller state carried from one sample to the next
	typedef struct packed {
		logic [ERR_W-1:0]   prev_err;
		logic [INTEG_W-1:0] integ;
	} ctrl_state_t;

endpackage

// ===== hw/rtl/pis_cfg_regs.sv =====
// pis_cfg_regs: configuration register file of the pid controller
// depends on pis_pkg for the register indexes and cfg_t
module pis_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [pis_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pis_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pis_pkg::cfg_t                    cfg
);

	pis_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain         <= '0;
			cfg_q.integ_gain        <= '0;
			cfg_q.deriv_gain        <= '0;
			cfg_q.integ_limit       <= pis_pkg::LIMIT_RESET;
			cfg_q.output_limit      <= pis_pkg::LIMIT_RESET;
			cfg_q.separation_enable <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				pis_pkg::REG_PROP_GAIN:    cfg_q.prop_gain         <= cfg_data;
				pis_pkg::REG_INTEG_GAIN:   cfg_q.integ_gain        <= cfg_data;
				pis_pkg::REG_DERIV_GAIN:   cfg_q.deriv_gain        <= cfg_data;
				pis_pkg::REG_INTEG_LIMIT:  cfg_q.integ_limit       <= cfg_data[14:0];
				pis_pkg::REG_OUTPUT_LIMIT: cfg_q.output_limit      <= cfg_data[14:0];
				pis_pkg::REG_SEP_ENABLE:   cfg_q.separation_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/pis_datapath.sv =====
// pis_datapath: combinational pid step, error, three gain products, clamps and rounding
// depends on pis_pkg for cfg_t, ctrl_state_t and the fixed-point constants
module pis_datapath (
	input  pis_pkg::cfg_t        cfg,
	input  pis_pkg::ctrl_state_t state_cur,
	input  logic [15:0]          reference,
	input  logic [15:0]          feedback,
	output pis_pkg::ctrl_state_t state_nxt,
	output logic [15:0]          drive
);

	// symmetric clamp to +/- lim in q.8, result always fits the integrator width
	function automatic logic [pis_pkg::INTEG_W-1:0] clamp_sym(
		input logic signed [35:0] x,
		input logic [14:0]        lim
	);
		logic signed [35:0] limx;
		logic signed [35:0] nlim;
		logic signed [35:0] r;
		limx = $signed({13'b0, lim, 8'b0});
		nlim = -limx;
		if (x > limx)
			r = limx;
		else if (x < nlim)
			r = nlim;
		else
			r = x;
		return r[pis_pkg::INTEG_W-1:0];
	endfunction

	logic signed [16:0] err;
	logic signed [17:0] err_diff;
	logic signed [32:0] pg_x, ig_x, err_x;
	logic signed [33:0] dg_x, diff_x;
	logic signed [32:0] p_term, i_prod;
	logic signed [33:0] d_term;
	logic signed [25:0] err_scaled, ref77;
	logic               update;
	logic signed [35:0] integ_sum;
	logic signed [35:0] integ_old;
	logic [23:0]        integ_new;
	logic signed [35:0] out_sum;
	logic [23:0]        out_clamped;
	logic signed [24:0] rounded;

	assign err      = $signed({reference[15], reference}) - $signed({feedback[15], feedback});
	assign err_diff = $signed({err[16], err}) - $signed({state_cur.prev_err[16], state_cur.prev_err});

	assign pg_x   = $signed({{17{cfg.prop_gain[15]}}, cfg.prop_gain});
	assign ig_x   = $signed({{17{cfg.integ_gain[15]}}, cfg.integ_gain});
	assign dg_x   = $signed({{18{cfg.deriv_gain[15]}}, cfg.deriv_gain});
	assign err_x  = $signed({{16{err[16]}}, err});
	assign diff_x = $signed({{16{err_diff[17]}}, err_diff});

	assign p_term = pg_x * err_x;
	assign i_prod = ig_x * err_x;
	assign d_term = dg_x * diff_x;

	// window: -77*ref < 256*err < 77*ref, empty for a non-positive reference
	assign err_scaled = $signed({err[16], err, 8'b0});
	assign ref77      = $signed({{10{reference[15]}}, reference}) * 26'sd77;
	assign update     = !cfg.separation_enable ||
	                    ((err_scaled > -ref77) && (err_scaled < ref77));

	assign integ_old = $signed({{12{state_cur.integ[23]}}, state_cur.integ});
	assign integ_sum = update ? integ_old + $signed({{3{i_prod[32]}}, i_prod}) : integ_old;
	assign integ_new = clamp_sym(integ_sum, cfg.integ_limit);

	assign out_sum = $signed({{3{p_term[32]}}, p_term})
	               + $signed({{12{integ_new[23]}}, integ_new})
	               + $signed({{2{d_term[33]}}, d_term});
	assign out_clamped = clamp_sym(out_sum, cfg.output_limit);

	// round to nearest, ties toward plus infinity
	assign rounded = $signed({out_clamped[23], out_clamped}) + 25'sd128;
	assign drive   = rounded[23:8];

	assign state_nxt.prev_err = err;
	assign state_nxt.integ    = integ_new;

endmodule

// ===== hw/rtl/pid_integral_separation.sv =====
// pid_integral_separation: positional pid controller with integral separation and clamps
// depends on pis_pkg, pis_cfg_regs and pis_datapath
//
// usage:
//   input channel in_valid/in_ready carries one sample (reference, feedback) per
//   transaction; output channel out_valid/out_ready carries the saturated drive.
//   configuration is a plain write port (cfg_write_en, cfg_index, cfg_data), taken
//   on any edge with cfg_write_en high; write it only while no sample is in flight.
//   a sample is held in an input register and its drive, computed combinationally,
//   is captured in the result register when that register is free or being emptied.
//   throughput is one sample per cycle while out_ready is high; the single step
//   through the three gain multipliers, the integrator clamp and the output clamp
//   sets that cycle. the integrator and previous error update as a sample moves into
//   the result register, so samples are processed strictly in order.
//   when the receiver stalls, the result register holds and the input register
//   still takes one more sample; in_ready then drops until the drive is taken.
//   reset clears gains, integrator, previous error and both valid flags, and sets
//   both limits to full scale.
module pid_integral_separation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [15:0]                    reference,
	input  logic [15:0]                    feedback,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [15:0]                    drive,
	input  logic                           cfg_write_en,
	input  logic [pis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pis_pkg::CFG_DATA_W-1:0] cfg_data
);

	pis_pkg::cfg_t        cfg;
	pis_pkg::ctrl_state_t state_q;
	pis_pkg::ctrl_state_t state_nxt;

	logic        valid_s1;
	logic [15:0] reference_s1;
	logic [15:0] feedback_s1;
	logic        valid_s2;
	logic [15:0] drive_s2;
	logic [15:0] drive_nxt;
	logic        advance;

	pis_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	pis_datapath u_dp (
		.cfg       (cfg),
		.state_cur (state_q),
		.reference (reference_s1),
		.feedback  (feedback_s1),
		.state_nxt (state_nxt),
		.drive     (drive_nxt)
	);

	// result register free or being emptied this cycle
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
			if (advance && valid_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			reference_s1 <= reference;
			feedback_s1  <= feedback;
		end
		if (advance && valid_s1)
			drive_s2 <= drive_nxt;
	end

	assign out_valid = valid_s2;
	assign drive     = drive_s2;

endmodule
